>>> sv/rrw_pkg.sv
// ----------------------------------------------------------------------------
// rrw_pkg
// Types, opcodes and helpers shared by the receive window modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrw_pkg;

  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 9;
  localparam int TAG_W  = 32;
  localparam int OP_W   = 3;
  localparam int SLOT_W = LEN_W + TAG_W;
  localparam int WALK_MAX = 16;

  localparam logic [OP_W-1:0] OP_RECEIVE   = 3'd0;
  localparam logic [OP_W-1:0] OP_HEARTBEAT = 3'd1;
  localparam logic [OP_W-1:0] OP_TAKE_NEXT = 3'd2;
  localparam logic [OP_W-1:0] OP_ACKNACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

  localparam logic [SEQ_W-1:0] MARK_RESET = 16'hFFFF;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [SEQ_W-1:0] seq_num;
    logic [SEQ_W-1:0] last_seq;
    logic [LEN_W-1:0] length;
    logic [TAG_W-1:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    logic             in_order;
    logic             delivered;
    logic [TAG_W-1:0] out_tag;
    logic [LEN_W-1:0] out_length;
    logic [SEQ_W-1:0] first_unacked;
    logic [WALK_MAX-1:0] miss_mask;
    logic             busy_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_EXEC,
    ST_READ,
    ST_WALK,
    ST_DONE
  } state_t;

  // Serial-number order: a precedes b when b - a is nonzero and below half range.
  function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage

>>> sv/rrw_ram.sv
// ----------------------------------------------------------------------------
// rrw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrw_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rrw_mod_unit.sv
// ----------------------------------------------------------------------------
// rrw_mod_unit
// Remainder of a 16-bit sequence number by the history depth, by reciprocal
// multiplication: product first, then quotient back-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrw_mod_unit
  import rrw_pkg::*;
#(
  parameter int HISTORY = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SEQ_W-1:0]           value,
  output logic                       done,
  output logic [$clog2(HISTORY)-1:0] rem
);

  localparam int IW = $clog2(HISTORY);
  localparam int KW = SEQ_W + IW;
  localparam int MW = SEQ_W + 1;
  localparam int PW = SEQ_W + MW;
  // Rounded-up reciprocal; with KW fraction bits the quotient is exact for
  // every 16-bit value.
  localparam logic [MW-1:0] RECIP = MW'((2 ** KW + HISTORY - 1) / HISTORY);

  logic [SEQ_W-1:0] x_r, x_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [IW-1:0]    rem_r, rem_nxt;
  logic             stage_r, stage_nxt;
  logic             done_r, done_nxt;
  logic [SEQ_W-1:0] quot;
  logic [SEQ_W-1:0] diff;

  always_comb begin
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    stage_nxt = 1'b0;
    done_nxt  = 1'b0;
    quot      = SEQ_W'(prod_r >> KW);
    diff      = x_r - quot * SEQ_W'(HISTORY);
    if (start) begin
      x_nxt     = value;
      prod_nxt  = PW'(value) * PW'(RECIP);
      stage_nxt = 1'b1;
    end else if (stage_r) begin
      rem_nxt  = diff[IW-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> sv/reliable_receive_window.sv
// ----------------------------------------------------------------------------
// reliable_receive_window
// Receive side of a reliable stream: in-order handling, out-of-order slots,
// heartbeat, take-next and acknack bitmap over 16-bit wrapping numbers.
// ----------------------------------------------------------------------------
// Path: heartbeat, clear and unknown opcodes go from exec to done; receive, take
// next and acknack first wait in the mod state for the remainder; a take next that
// pops a slot adds the read state, and acknack walks up to 16 slots.
// Items are handled one at a time; the next item is accepted in the cycle after the
// result is loaded, and a result still waiting on out_ready holds the block.
// Reset sets both marks to 65535 and empties all slots; the slot RAM is not cleared.
`timescale 1ns / 1ps

module reliable_receive_window
  import rrw_pkg::*;
#(
  parameter int HISTORY    = 8,
  parameter int SLOT_BYTES = 504
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IW = $clog2(HISTORY);
  localparam int WCW = $clog2(WALK_MAX);

  state_t              state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SEQ_W-1:0]    hm_r, hm_nxt;
  logic [SEQ_W-1:0]    am_r, am_nxt;
  logic [HISTORY-1:0]  occ_r, occ_nxt;
  logic [IW-1:0]       widx_r, widx_nxt;
  logic [WCW-1:0]      wcnt_r, wcnt_nxt;
  logic [WCW:0]        wlim_r, wlim_nxt;

  logic                mod_start;
  logic [SEQ_W-1:0]    mod_value;
  logic                mod_done;
  logic [IW-1:0]       mod_rem;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_rdata;

  logic                in_fire;
  logic [SEQ_W-1:0]    next_seq;
  logic [SEQ_W-1:0]    top_seq;
  logic [SEQ_W-1:0]    am_step;
  logic [SEQ_W-1:0]    span;
  logic [SEQ_W-1:0]    walk_seq;
  logic [LEN_W-1:0]    sat_len;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign next_seq = hm_r + 1'b1;
  assign top_seq  = hm_r + SEQ_W'(HISTORY);
  assign span     = am_r - hm_r;
  assign walk_seq = next_seq + SEQ_W'(wcnt_r);
  assign sat_len  = ({7'd0, item_r.length} > SEQ_W'(SLOT_BYTES)) ?
                    LEN_W'(SLOT_BYTES) : item_r.length;

  assign mod_start = in_fire && (in_item.opcode == OP_RECEIVE ||
                                 in_item.opcode == OP_TAKE_NEXT ||
                                 in_item.opcode == OP_ACKNACK);
  assign mod_value = (in_item.opcode == OP_RECEIVE) ? in_item.seq_num : next_seq;

  rrw_mod_unit #(
    .HISTORY (HISTORY)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  rrw_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (HISTORY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mod_rem),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mod_rem),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    hm_nxt        = hm_r;
    am_nxt        = am_r;
    occ_nxt       = occ_r;
    widx_nxt      = widx_r;
    wcnt_nxt      = wcnt_r;
    wlim_nxt      = wlim_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = {sat_len, item_r.payload_tag};
    am_step       = am_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt  = in_item;
          res_nxt   = '0;
          state_nxt = mod_start ? ST_MOD : ST_EXEC;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (item_r.opcode)
          OP_RECEIVE: begin
            if (seq_before(hm_r, item_r.seq_num) && !seq_before(top_seq, item_r.seq_num)) begin
              if (item_r.seq_num == next_seq) begin
                hm_nxt          = next_seq;
                res_nxt.in_order = 1'b1;
                if (seq_before(am_r, next_seq)) begin
                  am_step = next_seq;
                end
              end else if (!occ_r[mod_rem] && item_r.length != '0) begin
                // A zero-length early message leaves the slot empty.
                ram_we           = 1'b1;
                occ_nxt[mod_rem] = 1'b1;
              end
            end
            am_nxt = seq_before(am_step, item_r.seq_num) ? item_r.seq_num : am_step;
          end
          OP_HEARTBEAT: begin
            if (seq_before(next_seq, item_r.seq_num)) begin
              hm_nxt = item_r.seq_num - 1'b1;
            end
            if (seq_before(am_r, item_r.last_seq)) begin
              am_nxt = item_r.last_seq;
            end
          end
          OP_TAKE_NEXT: begin
            if (occ_r[mod_rem]) begin
              ram_re           = 1'b1;
              occ_nxt[mod_rem] = 1'b0;
              hm_nxt           = next_seq;
              state_nxt        = ST_READ;
            end
          end
          OP_ACKNACK: begin
            res_nxt.first_unacked = next_seq;
            res_nxt.miss_mask     = {{(WALK_MAX-1){1'b0}}, (span != '0)};
            wlim_nxt = (span > SEQ_W'(WALK_MAX)) ? (WCW+1)'(WALK_MAX) : span[WCW:0];
            widx_nxt = mod_rem;
            wcnt_nxt = '0;
            if (span != '0) begin
              state_nxt = ST_WALK;
            end
          end
          OP_CLEAR: begin
            occ_nxt = '0;
            hm_nxt  = MARK_RESET;
            am_nxt  = MARK_RESET;
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        res_nxt.delivered  = 1'b1;
        res_nxt.out_length = ram_rdata[SLOT_W-1:TAG_W];
        res_nxt.out_tag    = ram_rdata[TAG_W-1:0];
        state_nxt          = ST_DONE;
      end
      ST_WALK: begin
        if (!occ_r[widx_r]) begin
          res_nxt.miss_mask[wcnt_r] = 1'b1;
        end
        // The slot index restarts at zero when the sequence number itself wraps.
        widx_nxt = (widx_r == IW'(HISTORY - 1) || walk_seq == '1) ? '0 : widx_r + 1'b1;
        wcnt_nxt = wcnt_r + 1'b1;
        if ({1'b0, wcnt_r} + 1'b1 == wlim_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt          = res_r;
          out_nxt.busy_res = (am_r != hm_r);
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hm_r        <= MARK_RESET;
      am_r        <= MARK_RESET;
      occ_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hm_r        <= hm_nxt;
      am_r        <= am_nxt;
      occ_r       <= occ_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    widx_r <= widx_nxt;
    wcnt_r <= wcnt_nxt;
    wlim_r <= wlim_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> tb/reliable_receive_window_tb.sv
// ----------------------------------------------------------------------------
// reliable_receive_window_tb
// Self-checking bench for the receive window. Items go in through a
// valid/ready port, and a scoreboard model of the marks and slots predicts
// every result. Directed cases come first, then random streams of mostly
// in-window traffic under several sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reliable_receive_window_tb;
  import rrw_pkg::*;

  localparam int HIST        = 8;
  localparam int MAX_BYTES   = 504;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 60;

  // Opcodes the block does not decode; they must leave the state alone.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int errors        = 0;
  int cycle_count   = 0;

  // Scoreboard copy of the window state.
  logic [SEQ_W-1:0] handled;
  logic [SEQ_W-1:0] announced;
  logic [LEN_W-1:0] held_len [HIST];
  logic [TAG_W-1:0] held_tag [HIST];

  out_item_t pending_results[$];

  reliable_receive_window #(
    .HISTORY   (HIST),
    .SLOT_BYTES(MAX_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic precedes(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] gap;
    gap = b - a;
    return (gap != 16'd0) && (gap < 16'h8000);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < HIST; i++) begin
      held_len[i] = '0;
    end
    handled   = MARK_RESET;
    announced = MARK_RESET;
  endfunction

  // Applies one item to the scoreboard state and returns the result it causes.
  function automatic out_item_t window_outcome(input in_item_t it);
    out_item_t        r;
    logic [SEQ_W-1:0] nxt;
    logic [SEQ_W-1:0] top;
    logic [SEQ_W-1:0] span;
    logic [SEQ_W-1:0] sq;
    int unsigned      s;
    int unsigned      walk;
    r   = '0;
    nxt = handled + 16'd1;
    case (it.opcode)
      OP_RECEIVE: begin
        top = handled + 16'(HIST);
        if (precedes(handled, it.seq_num) && !precedes(top, it.seq_num)) begin
          if (it.seq_num == nxt) begin
            handled = nxt;
            if (precedes(announced, handled)) announced = handled;
            r.in_order = 1'b1;
          end else begin
            s = it.seq_num % HIST;
            // An occupied slot keeps its first message; a zero length stays empty.
            if (held_len[s] == '0) begin
              held_len[s] = (it.length > MAX_BYTES) ? LEN_W'(MAX_BYTES) : it.length;
              held_tag[s] = it.payload_tag;
            end
          end
        end
        if (precedes(announced, it.seq_num)) announced = it.seq_num;
      end
      OP_HEARTBEAT: begin
        if (precedes(nxt, it.seq_num)) handled = it.seq_num - 16'd1;
        if (precedes(announced, it.last_seq)) announced = it.last_seq;
      end
      OP_TAKE_NEXT: begin
        s = nxt % HIST;
        if (held_len[s] != '0) begin
          r.delivered  = 1'b1;
          r.out_tag    = held_tag[s];
          r.out_length = held_len[s];
          held_len[s]  = '0;
          handled      = nxt;
        end
      end
      OP_ACKNACK: begin
        span = announced - handled;
        walk = (span > 16'd16) ? 16 : int'(span);
        r.miss_mask[0] = (span != 16'd0);
        for (int i = 0; i < WALK_MAX; i++) begin
          sq = handled + 16'd1 + 16'(i);
          if (i < walk && held_len[sq % HIST] == '0) r.miss_mask[i] = 1'b1;
        end
        r.first_unacked = nxt;
      end
      OP_CLEAR: begin
        clear_window();
      end
      default: begin
      end
    endcase
    r.busy_res = (announced != handled);
    return r;
  endfunction

  // Drives one item, holds it until accepted and queues its expected result.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                           input logic [SEQ_W-1:0] lseq, input logic [LEN_W-1:0] len,
                           input logic [TAG_W-1:0] tag);
    in_item_t it;
    it.opcode      = op;
    it.seq_num     = seq;
    it.last_seq    = lseq;
    it.length      = len;
    it.payload_tag = tag;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(window_outcome(it));
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("in_order", want.in_order, out_item.in_order);
        check_field("delivered", want.delivered, out_item.delivered);
        check_field("out_tag", want.out_tag, out_item.out_tag);
        check_field("out_length", want.out_length, out_item.out_length);
        check_field("first_unacked", want.first_unacked, out_item.first_unacked);
        check_field("miss_mask", want.miss_mask, out_item.miss_mask);
        check_field("busy_res", want.busy_res, out_item.busy_res);
      end
    end
  end

  task automatic test_receive_window();
    send_item(OP_ACKNACK, 16'd0, 16'd0, 9'd0, 32'd0);
    // Handled mark starts at 65535, so sequence 0 is the wrap to next in order.
    send_item(OP_RECEIVE, 16'd0, 16'hFFFF, 9'd10, 32'h0000_0000);
    send_item(OP_RECEIVE, 16'd2, 16'd0, 9'd0, 32'h1234_5678);
    send_item(OP_RECEIVE, 16'd3, 16'd0, 9'h1FF, 32'hFFFF_FFFF);
    send_item(OP_RECEIVE, 16'd8, 16'd0, 9'd1, 32'hA5A5_5A5A);
    send_item(OP_RECEIVE, 16'd9, 16'd0, 9'd5, 32'hDEAD_BEEF);
    send_item(OP_RECEIVE, 16'd3, 16'd0, 9'd7, 32'h0BAD_F00D);
    send_item(OP_RECEIVE, 16'd1, 16'd0, 9'd504, 32'h5555_AAAA);
    send_item(OP_RECEIVE, 16'd0, 16'd0, 9'd3, 32'd1);
    send_item(OP_RECEIVE, 16'h8001, 16'd0, 9'd3, 32'd2);
  endtask

  task automatic test_take_and_acknack();
    send_item(OP_ACKNACK, 16'd0, 16'd0, 9'd0, 32'd0);
    send_item(OP_TAKE_NEXT, 16'd0, 16'd0, 9'd0, 32'd0);
    send_item(OP_HEARTBEAT, 16'd3, 16'd20, 9'd0, 32'd0);
    send_item(OP_TAKE_NEXT, 16'd0, 16'd0, 9'd0, 32'd0);
    send_item(OP_ACKNACK, 16'hFFFF, 16'hFFFF, 9'h1FF, 32'hFFFF_FFFF);
    send_item(OP_TAKE_NEXT, 16'd0, 16'd0, 9'd0, 32'd0);
  endtask

  task automatic test_heartbeat_and_clear();
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 9'h1FF, 32'hFFFF_FFFF);
    // Half-range distance on the last number must not raise the announced mark.
    send_item(OP_HEARTBEAT, 16'h7FF0, 16'h7FFF, 9'd0, 32'd0);
    send_item(OP_RECEIVE, 16'h7FF0, 16'd0, 9'd0, 32'd7);
    send_item(OP_HEARTBEAT, 16'h7FF0, 16'h8010, 9'd0, 32'd0);
    send_item(OP_ACKNACK, 16'd0, 16'd0, 9'd0, 32'd0);
    send_item(OP_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 9'h1FF, 32'hFFFF_FFFF);
    send_item(OP_LAST_UNUSED, 16'h0000, 16'h0000, 9'd0, 32'd0);
    send_item(OP_CLEAR, 16'd0, 16'd0, 9'd0, 32'd0);
  endtask

  // Mostly well-formed traffic around the handled mark, with some noise.
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] lseq;
    logic [LEN_W-1:0] len;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      seq  = 16'($urandom);
      lseq = 16'($urandom);
      len  = 9'($urandom);
      if (pick < 45) begin
        op   = OP_RECEIVE;
        pick = $urandom_range(99);
        if (pick < 85) seq = handled + 16'($urandom_range(1, HIST + 1));
        else if (pick < 90) seq = handled - 16'($urandom_range(0, 3));
        pick = $urandom_range(99);
        if (pick < 80) len = 9'($urandom_range(1, MAX_BYTES));
        else if (pick < 90) len = '0;
        else len = 9'($urandom_range(MAX_BYTES + 1, 511));
      end else if (pick < 60) begin
        op = OP_TAKE_NEXT;
      end else if (pick < 75) begin
        op = OP_ACKNACK;
      end else if (pick < 86) begin
        op = OP_HEARTBEAT;
        if ($urandom_range(9) != 0) begin
          seq  = handled + 16'($urandom_range(0, 12));
          lseq = handled + 16'($urandom_range(0, 24));
        end
      end else if (pick < 89) begin
        op = OP_CLEAR;
      end else if (pick < 92) begin
        op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else begin
        op = 3'($urandom);
      end
      send_item(op, seq, lseq, len, $urandom);
    end
  endtask

  initial begin
    clear_window();
    for (int i = 0; i < HIST; i++) begin
      held_tag[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_receive_window();
    test_take_and_acknack();
    test_heartbeat_and_clear();
    test_random_traffic(175, 0, 0);
    test_random_traffic(175, 72, 0);
    test_random_traffic(175, 0, 72);
    test_random_traffic(175, 22, 22);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rrw_pkg.sv
sv/rrw_ram.sv
sv/rrw_mod_unit.sv
sv/reliable_receive_window.sv
tb/reliable_receive_window_tb.sv
